/* rtl/core/box_blur_3x3_rgb_unit_assert.svh */
// Assertion macros used by the box blur controller
`ifndef BOX_BLUR_3X3_RGB_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BB3_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BB3_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bb3_pkg.sv */
// Types, constants and helper functions of the 3x3 RGB box blur
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int RECIP_SHIFT   = 18;

    typedef struct packed {
        logic       cmd;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SUM,
        S_MUL,
        S_OUT,
        S_DRD,
        S_DCAP
    } t_state;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic       cap_in;
        logic       rd;
        logic       wr;
        logic       shift;
        logic       dcap;
        logic [1:0] dcol;
        logic       sum;
        logic       mul;
        logic       load;
        logic       last;
        logic [8:0] mask;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    // ceil(2^RECIP_SHIFT / (2*n))
    function automatic logic [17:0] f_recip(input logic [3:0] n);
        logic [17:0] m;
        case (n)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd5:    m = 18'd26215;
            4'd6:    m = 18'd21846;
            4'd7:    m = 18'd18725;
            4'd8:    m = 18'd16384;
            4'd9:    m = 18'd14564;
            default: m = 18'd0;
        endcase
        return m;
    endfunction

    // window cells in rows r0..r1 and columns c0..c1
    function automatic logic [8:0] f_mask(input logic [1:0] r0, input logic [1:0] r1,
                                          input logic [1:0] c0, input logic [1:0] c1);
        logic [8:0] m;
        m = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m[i*3+j] = (2'(i) >= r0) && (2'(i) <= r1) && (2'(j) >= c0) && (2'(j) <= c1);
            end
        end
        return m;
    endfunction

endpackage

/* rtl/core/bb3_dp.sv */
// Datapath of the box blur: line stores, window, sums, reciprocal divide, output register
module bb3_dp #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
    parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bb3_pkg::t_in_item  i_in_data,
    input  bb3_pkg::t_dp_cmd   i_cmd,
    input  logic [AW-1:0]      i_addr,
    output bb3_pkg::t_dp_stat  o_stat,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output bb3_pkg::t_out_item o_out_data
);
    import bb3_pkg::*;

    logic [23:0] r_upper [MAX_WIDTH];
    logic [23:0] r_middle [MAX_WIDTH];
    logic [23:0] r_up_q;
    logic [23:0] r_mid_q;
    logic [23:0] r_pix;
    logic [23:0] r_win [9];
    logic [11:0] r_sum [3];
    logic [3:0]  r_cnt;
    logic [7:0]  r_q [3];
    logic        r_ovalid;
    t_out_item   r_out;

    logic [11:0] n_sum [3];
    logic [3:0]  n_cnt;
    logic [7:0]  n_q [3];
    logic [17:0] w_recip;
    logic [12:0] w_num [3];
    logic [30:0] w_prod [3];
    logic        w_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_up_q  <= r_upper[i_addr];
            r_mid_q <= r_middle[i_addr];
        end
        if (i_cmd.wr) begin
            r_upper[i_addr]  <= r_mid_q;
            r_middle[i_addr] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_pix <= {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3]   <= r_win[i*3+1];
                r_win[i*3+1] <= r_win[i*3+2];
            end
            r_win[2] <= r_up_q;
            r_win[5] <= r_mid_q;
            r_win[8] <= r_pix;
        end else if (i_cmd.dcap) begin
            case (i_cmd.dcol)
                2'd0: begin
                    r_win[0] <= r_up_q;
                    r_win[3] <= r_mid_q;
                end
                2'd1: begin
                    r_win[1] <= r_up_q;
                    r_win[4] <= r_mid_q;
                end
                2'd2: begin
                    r_win[2] <= r_up_q;
                    r_win[5] <= r_mid_q;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_cnt = 4'(0);
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = '0;
        end
        for (int i = 0; i < 9; i++) begin
            if (i_cmd.mask[i]) begin
                n_cnt    = n_cnt + 4'd1;
                n_sum[0] = n_sum[0] + 12'(r_win[i][23:16]);
                n_sum[1] = n_sum[1] + 12'(r_win[i][15:8]);
                n_sum[2] = n_sum[2] + 12'(r_win[i][7:0]);
            end
        end
    end

    always_comb begin
        w_recip = f_recip(r_cnt);
        for (int k = 0; k < 3; k++) begin
            w_num[k]  = {r_sum[k], 1'b0} + 13'(r_cnt);
            w_prod[k] = 31'(w_num[k]) * 31'(w_recip);
            n_q[k]    = w_prod[k][RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
        if (i_cmd.mul) begin
            r_q <= n_q;
        end
    end

    assign w_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= '{red_out: r_q[0], green_out: r_q[1], blue_out: r_q[2],
                       frame_last: i_cmd.last};
        end
    end

    assign o_stat.out_free = w_free;
    assign o_out_valid     = r_ovalid;
    assign o_out_data      = r_out;

endmodule

/* rtl/core/bb3_ctrl.sv */
// Controller of the box blur: sequencer, frame counters and window selection
module bb3_ctrl #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
    parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_cmd,
    output logic              o_stall,
    input  logic [11:0]       i_width,
    input  logic [15:0]       i_height,
    output bb3_pkg::t_dp_cmd  o_cmd,
    output logic [AW-1:0]     o_addr,
    input  bb3_pkg::t_dp_stat i_stat
);
    import bb3_pkg::*;

    `include "box_blur_3x3_rgb_unit_assert.svh"

    localparam logic [13:0] MAXW = 14'(MAX_WIDTH);

    t_state        r_state, n_state;
    logic [15:0]   r_row;
    logic [AW-1:0] r_col;
    logic [AW-1:0] r_drain;
    logic [1:0]    r_j;
    logic [8:0]    r_mask_a, r_mask_b;
    logic          r_last_a;
    logic [1:0]    r_pend;

    logic [13:0] w_weff;
    logic [15:0] h_eff;
    logic        w_lastcol, w_dlast, w_need1, w_need2;
    logic [1:0]  w_r0;
    logic [8:0]  w_m1, w_m2, w_dmask;
    logic [AW:0] w_daddr;

    always_comb begin
        if (i_width == 12'd0) begin
            w_weff = 14'd1;
        end else if (14'(i_width) > MAXW) begin
            w_weff = MAXW;
        end else begin
            w_weff = 14'(i_width);
        end
        h_eff     = (i_height == 16'd0) ? 16'd1 : i_height;
        w_lastcol = (14'(r_col) + 14'd1) >= w_weff;
        w_dlast   = (14'(r_drain) + 14'd1) >= w_weff;
        w_r0      = (r_row >= 16'd2) ? 2'd0 : 2'd1;
        w_need1   = (r_row >= 16'd1) && (r_col != '0);
        w_need2   = (r_row >= 16'd1) && w_lastcol;
        w_m1      = f_mask(w_r0, 2'd2, (14'(r_col) >= 14'd2) ? 2'd0 : 2'd1, 2'd2);
        w_m2      = f_mask(w_r0, 2'd2, (r_col != '0) ? 2'd1 : 2'd2, 2'd2);
        w_dmask   = f_mask((h_eff >= 16'd2) ? 2'd0 : 2'd1, 2'd1,
                           (r_drain != '0) ? 2'd0 : 2'd1, w_dlast ? 2'd1 : 2'd2);
        w_daddr   = {1'b0, r_drain} + (AW+1)'(r_j) - (AW+1)'(1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_cmd == CMD_PIXEL && r_row < h_eff) begin
                    n_state = S_SHIFT;
                end else if (i_valid && i_cmd == CMD_DRAIN && r_row >= h_eff) begin
                    n_state = S_DRD;
                end
            end
            S_SHIFT: n_state = (w_need1 || w_need2) ? S_SUM : S_IDLE;
            S_SUM:   n_state = S_MUL;
            S_MUL:   n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = (r_pend == 2'd2) ? S_SUM : S_IDLE;
                end
            end
            S_DRD:   n_state = S_DCAP;
            S_DCAP:  n_state = (r_j == 2'd2) ? S_SUM : S_DRD;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_addr  = r_col;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.cap_in = i_valid;
                o_cmd.rd     = i_valid;
            end
            S_SHIFT: begin
                o_cmd.wr    = 1'b1;
                o_cmd.shift = 1'b1;
            end
            S_SUM: begin
                o_cmd.sum  = 1'b1;
                o_cmd.mask = r_mask_a;
            end
            S_MUL: o_cmd.mul = 1'b1;
            S_OUT: begin
                o_cmd.load = i_stat.out_free;
                o_cmd.last = r_last_a;
            end
            S_DRD: begin
                o_cmd.rd = 1'b1;
                o_addr   = w_daddr[AW-1:0];
            end
            S_DCAP: begin
                o_cmd.dcap = 1'b1;
                o_cmd.dcol = r_j;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_drain  <= '0;
            r_j      <= '0;
            r_pend   <= '0;
            r_last_a <= 1'b0;
            r_mask_a <= '0;
            r_mask_b <= '0;
        end else begin
            case (r_state)
                S_IDLE: r_j <= '0;
                S_SHIFT: begin
                    r_last_a <= 1'b0;
                    if (w_need1) begin
                        r_mask_a <= w_m1;
                        r_mask_b <= w_m2;
                        r_pend   <= w_need2 ? 2'd2 : 2'd1;
                    end else begin
                        r_mask_a <= w_m2;
                        r_pend   <= w_need2 ? 2'd1 : 2'd0;
                    end
                    if (w_lastcol) begin
                        r_col <= '0;
                        r_row <= r_row + 16'd1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_stat.out_free) begin
                        r_mask_a <= r_mask_b;
                        r_last_a <= 1'b0;
                        r_pend   <= r_pend - 2'd1;
                    end
                end
                S_DCAP: begin
                    r_j <= r_j + 2'd1;
                    if (r_j == 2'd2) begin
                        r_mask_a <= w_dmask;
                        r_last_a <= w_dlast;
                        r_pend   <= 2'd1;
                        if (w_dlast) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_drain <= '0;
                        end else begin
                            r_drain <= r_drain + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `BB3_ASSERT_IMP(a_load_free, o_cmd.load, i_stat.out_free, "result loaded into busy output")
    `BB3_ASSERT_IMP(a_out_pend, r_state == S_OUT, r_pend == 2'd1 || r_pend == 2'd2, "no pending result in output state")
    `BB3_ASSERT_NXT(a_pix_shift, r_state == S_IDLE && i_valid && i_cmd == CMD_PIXEL && r_row < h_eff, r_state == S_SHIFT, "pixel transaction not shifted in")
    `BB3_ASSERT_NXT(a_drain_sum, r_state == S_DCAP && r_j == 2'd2, r_state == S_SUM && r_pend == 2'd1, "drain column fetch did not end in a sum")

endmodule

/* rtl/core/box_blur_3x3_rgb_unit.sv */
// Top level of the streaming 3x3 RGB box blur with its register port
// Input channel: i_in_valid / o_in_stall carry one transaction per pixel (cmd = 0) or per
// drain request (cmd = 1). Output channel: o_out_valid / i_out_stall carry blurred pixels.
// Pixels arrive in raster order; a result appears one row and one column behind the input.
// After the last input row, one drain transaction per pixel emits the last row, and the
// final pixel carries frame_last.
// Each pixel is captured and shifted into the window; each result then takes a sum, a
// reciprocal multiply and an output load step; a drain first reads three line store columns.
// The sum/multiply path is shared by all results, and the line stores use a single address.
// The output register holds one finished pixel; the next transaction is accepted while it
// waits, and the sequencer holds at its load step while the receiver stalls.
// Registers: image_width at address 0, image_height at address 4; write only while idle.
// Reset sets both registers to 1, clears the counters and the window, and empties the
// output register; the line stores are not cleared and need no clearing pass.
module box_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bb3_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bb3_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bb3_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [11:0]   r_width;
    logic [15:0]   r_height;
    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic [AW-1:0] w_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd1;
            r_height <= 16'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_height <= pwdata[15:0];
            end else begin
                r_width <= pwdata[11:0];
            end
        end
    end

    assign prdata = paddr[2] ? {16'd0, r_height} : {20'd0, r_width};
    assign pready = 1'b1;

    bb3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_cmd    (i_in_data.cmd),
        .o_stall  (o_in_stall),
        .i_width  (r_width),
        .i_height (r_height),
        .o_cmd    (w_cmd),
        .o_addr   (w_addr),
        .i_stat   (w_stat)
    );

    bb3_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_addr      (w_addr),
        .o_stat      (w_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* verif/tb_box_blur_3x3_rgb_unit.sv */
// Testbench for the streaming 3x3 RGB box blur: directed corner cases and random frames checked against a predictor
`timescale 1ns / 100ps

import bb3_pkg::*;

class blur_scoreboard;
    bit [11:0] width_reg = 12'd1;
    bit [15:0] height_reg = 16'd1;
    bit [23:0] upper_row[2048];
    bit [23:0] middle_row[2048];
    bit [23:0] win[9];
    int unsigned row_idx;
    int unsigned col_idx;
    int unsigned drain_idx;
    t_out_item expected_px[$];
    int errors;

    function int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > 2048) return 2048;
        return width_reg;
    endfunction

    function int eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function void push_mean(bit [23:0] px[$], bit last);
        t_out_item o;
        int unsigned s[3];
        int unsigned n;
        n = px.size();
        s = '{0, 0, 0};
        foreach (px[i]) begin
            s[0] += px[i][23:16];
            s[1] += px[i][15:8];
            s[2] += px[i][7:0];
        end
        o.red_out = 8'((2 * s[0] + n) / (2 * n));
        o.green_out = 8'((2 * s[1] + n) / (2 * n));
        o.blue_out = 8'((2 * s[2] + n) / (2 * n));
        o.frame_last = last;
        expected_px.push_back(o);
    endfunction

    function void push_window(int r0, int c0);
        bit [23:0] px[$];
        for (int i = r0; i < 3; i++)
            for (int j = c0; j < 3; j++)
                px.push_back(win[i*3+j]);
        push_mean(px, 1'b0);
    endfunction

    // returns 1 when the transaction is acted on, 0 when it is dropped
    function bit note(t_in_item it);
        int w;
        int h;
        int r0;
        bit last;
        bit [23:0] px[$];
        w = eff_width();
        h = eff_height();
        if (it.cmd == CMD_PIXEL) begin
            if (row_idx >= h) return 0;
            for (int i = 0; i < 3; i++) begin
                win[i*3] = win[i*3+1];
                win[i*3+1] = win[i*3+2];
            end
            win[2] = upper_row[col_idx];
            win[5] = middle_row[col_idx];
            win[8] = {it.red_in, it.green_in, it.blue_in};
            upper_row[col_idx] = middle_row[col_idx];
            middle_row[col_idx] = win[8];
            last = (col_idx + 1 >= w);
            if (row_idx >= 1) begin
                r0 = (row_idx >= 2) ? 0 : 1;
                if (col_idx >= 1) push_window(r0, (col_idx >= 2) ? 0 : 1);
                if (last) push_window(r0, (col_idx >= 1) ? 1 : 2);
            end
            if (last) begin
                col_idx = 0;
                row_idx++;
            end else begin
                col_idx++;
            end
            return 1;
        end
        if (row_idx < h) return 0;
        last = (drain_idx + 1 >= w);
        if (drain_idx >= 1) begin
            if (h >= 2) px.push_back(upper_row[drain_idx-1]);
            px.push_back(middle_row[drain_idx-1]);
        end
        if (h >= 2) px.push_back(upper_row[drain_idx]);
        px.push_back(middle_row[drain_idx]);
        if (!last) begin
            if (h >= 2) px.push_back(upper_row[drain_idx+1]);
            px.push_back(middle_row[drain_idx+1]);
        end
        push_mean(px, last);
        if (last) begin
            row_idx = 0;
            col_idx = 0;
            drain_idx = 0;
        end else begin
            drain_idx++;
        end
        return 1;
    endfunction

    function void check(t_out_item got);
        t_out_item exp_px;
        if (expected_px.size() == 0) begin
            $error("unexpected output transaction %h", got);
            errors++;
            return;
        end
        exp_px = expected_px.pop_front();
        if (got.red_out !== exp_px.red_out) begin
            $error("red_out exp %0d got %0d", exp_px.red_out, got.red_out);
            errors++;
        end
        if (got.green_out !== exp_px.green_out) begin
            $error("green_out exp %0d got %0d", exp_px.green_out, got.green_out);
            errors++;
        end
        if (got.blue_out !== exp_px.blue_out) begin
            $error("blue_out exp %0d got %0d", exp_px.blue_out, got.blue_out);
            errors++;
        end
        if (got.frame_last !== exp_px.frame_last) begin
            $error("frame_last exp %0d got %0d", exp_px.frame_last, got.frame_last);
            errors++;
        end
    endfunction
endclass

module tb_box_blur_3x3_rgb_unit;
    localparam logic [2:0] ADDR_WIDTH = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    blur_scoreboard sb = new();
    bit calm;
    int taken_cnt;
    int idle_cycles;

    box_blur_3x3_rgb_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 14);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check(o_out_data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb_box_blur_3x3_rgb_unit: FAIL");
            $finish;
        end
    end

    task automatic send(input t_in_item it);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(99) < 14) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data <= it;
                break;
            end
        end
        do @(posedge i_clk); while (o_in_stall);
        if (sb.note(it)) taken_cnt++;
    endtask

    task automatic send_pixel(input logic [23:0] rgb);
        t_in_item it;
        it.cmd = CMD_PIXEL;
        {it.red_in, it.green_in, it.blue_in} = rgb;
        send(it);
    endtask

    task automatic send_drain();
        t_in_item it;
        it.cmd = CMD_DRAIN;
        {it.red_in, it.green_in, it.blue_in} = 24'($urandom);
        send(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_WIDTH) sb.width_reg = value[11:0];
        else sb.height_reg = value[15:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_frame(input int w, input int h);
        reg_write(ADDR_WIDTH, w);
        reg_write(ADDR_HEIGHT, h);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if ($urandom_range(39) == 0) send_drain();
                send_pixel(24'($urandom));
            end
        end
        if ($urandom_range(3) == 0) send_pixel(24'($urandom));
        for (int d = 0; d < w; d++) send_drain();
        wait_drained();
    endtask

    initial begin
        int frame_no;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        reg_write(ADDR_WIDTH, 0);
        reg_write(ADDR_HEIGHT, 0);
        send_drain();
        send_pixel(24'hFFFFFF);
        send_pixel(24'h123456);
        send_drain();
        wait_drained();

        reg_write(ADDR_WIDTH, 3);
        reg_write(ADDR_HEIGHT, 16'hFFFF);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hAA55AA);
        send_pixel(24'h55AA55);
        send_pixel(24'hFF00FF);
        send_pixel(24'h00FF00);
        send_drain();
        wait_drained();
        reg_write(ADDR_HEIGHT, 2);
        repeat (3) send_drain();
        wait_drained();

        taken_cnt = 0;
        frame_no = 0;
        while (taken_cnt < 550) begin
            calm = (frame_no >= 4 && frame_no < 8);
            if ($urandom_range(9) == 0)
                run_frame($urandom_range(9, 40), $urandom_range(1, 4));
            else
                run_frame($urandom_range(1, 8), $urandom_range(1, 6));
            frame_no++;
        end
        calm = 1'b0;
        wait_drained();

        if (sb.errors == 0 && sb.expected_px.size() == 0) begin
            $display("tb_box_blur_3x3_rgb_unit: PASS");
        end else begin
            $display("tb_box_blur_3x3_rgb_unit: FAIL");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bb3_pkg.sv
rtl/core/bb3_dp.sv
rtl/core/bb3_ctrl.sv
rtl/core/box_blur_3x3_rgb_unit.sv
verif/tb_box_blur_3x3_rgb_unit.sv
